// File: hdl/stepper_angle_positioner_defines.svh
// Assertion macros used by the stepper angle positioner RTL.
`ifndef STEPPER_ANGLE_POSITIONER_DEFINES_SVH
`define STEPPER_ANGLE_POSITIONER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SAP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/sap_pkg.sv
// Package with types and constants of the stepper angle positioner.
package sap_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int ANGLE_W             = 16;

    // Request codes carried in the action field.
    typedef enum logic [1:0] {
        ACT_MOVE  = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_LIMIT = 2'd2
    } action_t;

    // Configuration register indexes.
    localparam logic CFG_MIN_ANGLE = 1'b0;
    localparam logic CFG_MAX_ANGLE = 1'b1;

    // One step is 19.1808 angle units. The goal is the difference times 625,
    // plus half a step, divided by 11988, computed with an exact reciprocal.
    localparam int          STEP_BIAS   = 5994;
    localparam int          RECIP_SHIFT = 40;
    localparam longint      STEP_DIV    = 64'd11988;
    localparam logic [26:0] STEP_RECIP  =
        27'(((64'd1 << RECIP_SHIFT) + STEP_DIV - 64'd1) / STEP_DIV);

    // Outcome of a move request handed from the move calculator.
    typedef struct packed {
        logic signed [ANGLE_W-1:0] target;
        logic                      cw;
    } move_calc_t;

endpackage

// File: hdl/sap_move_calc.sv
// Clamping, direction and step goal for a move request.
module sap_move_calc
    import sap_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic signed [ANGLE_W-1:0] target_angle,
    input  logic signed [ANGLE_W-1:0] position,
    input  logic signed [ANGLE_W-1:0] min_angle,
    input  logic signed [ANGLE_W-1:0] max_angle,
    output move_calc_t                mv,
    output logic [COUNT_WIDTH-1:0]    goal
);

    logic signed [ANGLE_W-1:0] lo_clamped;
    logic signed [ANGLE_W-1:0] clamped;
    logic signed [ANGLE_W:0]   diff;
    logic [ANGLE_W-1:0]        abs_diff;
    logic [25:0]               abs_diff_w;
    logic [25:0]               num;
    logic [52:0]               prod;
    logic [12:0]               quot;
    logic [31:0]               quot_w;
    logic [31:0]               count_max;

    always_comb
    begin
        lo_clamped = (target_angle < min_angle) ? min_angle : target_angle;
        // The upper clamp comes last, so it wins when min is above max.
        clamped    = (lo_clamped > max_angle) ? max_angle : lo_clamped;
        diff       = (ANGLE_W+1)'(clamped) - (ANGLE_W+1)'(position);
        abs_diff   = diff[ANGLE_W] ? ANGLE_W'(-diff) : diff[ANGLE_W-1:0];
        abs_diff_w = 26'(abs_diff);
        // Times 625 as 512 + 128 - 16 + 1.
        num        = (abs_diff_w << 9) + (abs_diff_w << 7) - (abs_diff_w << 4) + abs_diff_w
                   + 26'(STEP_BIAS);
        prod       = 53'(num) * 53'(STEP_RECIP);
        quot       = prod[52:RECIP_SHIFT];
        quot_w     = 32'(quot);
        count_max  = 32'((64'd1 << COUNT_WIDTH) - 64'd1);
        goal       = (quot_w > count_max) ? count_max[COUNT_WIDTH-1:0]
                                          : quot_w[COUNT_WIDTH-1:0];
        mv.target  = clamped;
        mv.cw      = clamped > position;
    end

endmodule

// File: hdl/stepper_angle_positioner.sv
// Top level of the stepper angle positioner: request stage, state and result register.
// A request moves from the input stage into the result register, which holds it
// until res_ready. Throughput: one request per cycle unless res_ready stalls.
// The input stage and the result register form a two-entry pipeline, so a request
// is still taken while a result waits, provided the input stage is empty.
// Reset (rst_n low, asynchronous) clears the angle limits, position, direction,
// motion, tick phase, step counter and goal, and empties both stages.
`include "stepper_angle_positioner_defines.svh"

module stepper_angle_positioner
    import sap_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Configuration write port.
    input  logic                      cfg_wr_en,
    input  logic                      cfg_index,
    input  logic [ANGLE_W-1:0]        cfg_data,
    // Request channel.
    input  logic                      req_valid,
    output logic                      req_ready,
    input  logic [1:0]                action,
    input  logic signed [ANGLE_W-1:0] target_angle,
    input  logic                      driver_ready,
    input  logic                      cw_limit_closed,
    input  logic                      ccw_limit_closed,
    // Result channel.
    output logic                      res_valid,
    input  logic                      res_ready,
    output logic                      running,
    output logic                      clockwise,
    output logic [15:0]               steps_done,
    output logic                      step_counted,
    output logic signed [ANGLE_W-1:0] position
);

    // Configuration registers.
    logic signed [ANGLE_W-1:0] min_angle_reg;
    logic signed [ANGLE_W-1:0] max_angle_reg;

    // Request stage.
    logic                      req_valid_reg;
    logic [1:0]                action_reg;
    logic signed [ANGLE_W-1:0] target_reg;
    logic                      drv_ready_reg;
    logic                      cw_limit_reg;
    logic                      ccw_limit_reg;

    // Axis state.
    logic signed [ANGLE_W-1:0] pos_reg,     pos_next;
    logic                      cw_reg,      cw_next;
    logic                      moving_reg,  moving_next;
    logic                      phase_reg,   phase_next;
    logic [COUNT_WIDTH-1:0]    counter_reg, counter_next;
    logic [COUNT_WIDTH-1:0]    goal_reg,    goal_next;

    // Result register.
    logic                      res_valid_reg;
    logic                      res_running_reg;
    logic                      res_cw_reg;
    logic [15:0]               res_steps_reg;
    logic                      res_counted_reg;
    logic signed [ANGLE_W-1:0] res_pos_reg;

    logic                      advance;
    logic                      counted_next;
    logic                      new_blocked;
    logic                      cur_blocked;
    logic [COUNT_WIDTH-1:0]    counter_inc;
    logic [31:0]               counter_w;
    logic [COUNT_WIDTH-1:0]    move_goal;
    move_calc_t                mv;

    // The request stage moves on whenever the result register is free or
    // being drained this cycle.
    assign advance   = req_valid_reg && (!res_valid_reg || res_ready);
    assign req_ready = !req_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_angle_reg <= '0;
            max_angle_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MIN_ANGLE: min_angle_reg <= cfg_data;
                CFG_MAX_ANGLE: max_angle_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            req_valid_reg <= req_valid;
        end
    end

    // Request payload needs no reset; it is only used while marked valid.
    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            action_reg    <= action;
            target_reg    <= target_angle;
            drv_ready_reg <= driver_ready;
            cw_limit_reg  <= cw_limit_closed;
            ccw_limit_reg <= ccw_limit_closed;
        end
    end

    sap_move_calc #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_move_calc (
        .target_angle (target_reg),
        .position     (pos_reg),
        .min_angle    (min_angle_reg),
        .max_angle    (max_angle_reg),
        .mv           (mv),
        .goal         (move_goal)
    );

    // A limit switch only blocks travel toward it. A move tests the switch
    // in its new direction; a limit event tests the current one.
    assign new_blocked = (cw_limit_reg && mv.cw) || (ccw_limit_reg && !mv.cw);
    assign cur_blocked = (cw_limit_reg && cw_reg) || (ccw_limit_reg && !cw_reg);
    assign counter_inc = counter_reg + COUNT_WIDTH'(1);

    always_comb
    begin
        pos_next     = pos_reg;
        cw_next      = cw_reg;
        moving_next  = moving_reg;
        phase_next   = phase_reg;
        counter_next = counter_reg;
        goal_next    = goal_reg;
        counted_next = 1'b0;
        case (action_t'(action_reg))
            ACT_MOVE:
            begin
                // A move to the recorded angle, or with the driver busy,
                // changes nothing. A blocked start still records the new
                // target, direction and goal, and leaves motion as it was.
                if (drv_ready_reg && (target_reg != pos_reg))
                begin
                    pos_next  = mv.target;
                    cw_next   = mv.cw;
                    goal_next = move_goal;
                    if (!new_blocked)
                    begin
                        counter_next = '0;
                        moving_next  = 1'b1;
                    end
                end
            end
            ACT_TICK:
            begin
                // Every second tick while moving counts a full step. The
                // phase is kept across moves.
                if (moving_reg)
                begin
                    phase_next = !phase_reg;
                    if (phase_reg)
                    begin
                        counter_next = counter_inc;
                        counted_next = 1'b1;
                        if (counter_inc >= goal_reg)
                        begin
                            moving_next = 1'b0;
                        end
                    end
                end
            end
            ACT_LIMIT:
            begin
                if (cur_blocked)
                begin
                    moving_next = 1'b0;
                end
            end
            default:
            begin
                // The unused code leaves the state alone and reports it.
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            cw_reg      <= 1'b0;
            moving_reg  <= 1'b0;
            phase_reg   <= 1'b0;
            counter_reg <= '0;
            goal_reg    <= '0;
        end
        else if (advance)
        begin
            pos_reg     <= pos_next;
            cw_reg      <= cw_next;
            moving_reg  <= moving_next;
            phase_reg   <= phase_next;
            counter_reg <= counter_next;
            goal_reg    <= goal_next;
        end
    end

    // Only the low 16 bits of the counter are reported.
    assign counter_w = 32'(counter_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg   <= 1'b0;
            res_counted_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg   <= 1'b1;
            res_counted_reg <= counted_next;
        end
        else if (res_ready)
        begin
            res_valid_reg   <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_running_reg <= moving_next;
            res_cw_reg      <= cw_next;
            res_steps_reg   <= counter_w[15:0];
            res_pos_reg     <= pos_next;
        end
    end

    assign res_valid    = res_valid_reg;
    assign running      = res_running_reg;
    assign clockwise    = res_cw_reg;
    assign steps_done   = res_steps_reg;
    assign step_counted = res_counted_reg;
    assign position     = res_pos_reg;

    // A request held in the input stage is never dropped while stalled.
    `SAP_ASSERT_NEXT(a_req_held, clk, rst_n, req_valid_reg && !advance, req_valid_reg,
        "request stage lost a stalled request")

    // A counted step always leaves the tick phase back at zero.
    `SAP_ASSERT_SAME(a_count_phase, clk, rst_n, res_valid_reg && res_counted_reg,
        !phase_reg, "step counted with tick phase still set")

    // A tick while stopped must not touch the counter or the phase.
    `SAP_ASSERT_NEXT(a_idle_tick, clk, rst_n,
        advance && (action_reg == ACT_TICK) && !moving_reg,
        (counter_reg == $past(counter_reg)) && (phase_reg == $past(phase_reg)),
        "tick while stopped changed the step state")

    // A limit event in the travel direction always stops motion.
    `SAP_ASSERT_NEXT(a_limit_stop, clk, rst_n,
        advance && (action_reg == ACT_LIMIT) && cur_blocked,
        !moving_reg && res_valid_reg && !res_running_reg,
        "limit event did not stop motion")

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the stepper angle positioner: stimulus, axis predictor, checker.
`timescale 1ns / 1ps

module tb_top;
    import sap_pkg::*;

    // Action code 3 has no meaning in the block; it must leave the state alone.
    localparam logic [1:0] ACT_SPARE = 2'd3;

    // One step is 0.2997 degree, i.e. 19.1808 units of 1/64 degree. The goal is
    // the angle difference divided by that, rounded half up.
    localparam longint STEPS_NUM = 20000;
    localparam longint STEPS_DEN = 383616;

    // Run limit in clock cycles, for the watchdog.
    localparam int CYCLE_LIMIT = 200000;

    // Length of the receiver hold-off that fills the block and stalls requests.
    localparam int HOLD_CYCLES   = 60;
    localparam int HOLD_AFTER    = 100;

    typedef struct {
        logic [1:0]                action;
        logic signed [ANGLE_W-1:0] target;
        logic                      drv_ready;
        logic                      cw_lim;
        logic                      ccw_lim;
    } move_req_t;

    typedef struct {
        logic                      running;
        logic                      clockwise;
        logic [15:0]               steps;
        logic                      counted;
        logic signed [ANGLE_W-1:0] position;
    } axis_status_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic                      cfg_index = CFG_MIN_ANGLE;
    logic [ANGLE_W-1:0]        cfg_data = '0;
    logic                      req_valid = 1'b0;
    logic                      req_ready;
    logic [1:0]                action = ACT_SPARE;
    logic signed [ANGLE_W-1:0] target_angle = '0;
    logic                      driver_ready = 1'b0;
    logic                      cw_limit_closed = 1'b0;
    logic                      ccw_limit_closed = 1'b0;
    logic                      res_valid;
    logic                      res_ready = 1'b0;
    logic                      running;
    logic                      clockwise;
    logic [15:0]               steps_done;
    logic                      step_counted;
    logic signed [ANGLE_W-1:0] position;

    // Requests waiting to be driven, and results predicted but not yet seen.
    move_req_t    req_backlog[$];
    axis_status_t status_due[$];
    move_req_t    head_req;
    move_req_t    seen_req;
    axis_status_t want;

    // Predictor copy of the axis state and of the angle limits.
    logic signed [ANGLE_W-1:0] ax_pos    = '0;
    logic                      ax_cw     = 1'b0;
    logic                      ax_moving = 1'b0;
    logic                      ax_phase  = 1'b0;
    logic [15:0]               ax_count  = '0;
    logic [15:0]               ax_goal   = '0;
    logic signed [ANGLE_W-1:0] lim_lo    = '0;
    logic signed [ANGLE_W-1:0] lim_hi    = '0;

    // Bookkeeping shared by the processes below.
    bit req_taken    = 1'b0;
    bit steady       = 1'b0;
    bit hold_done    = 1'b0;
    int hold_left    = 0;
    int faults       = 0;
    int reqs_sent    = 0;
    int results_seen = 0;
    int ax_starts    = 0;
    int ax_steps     = 0;
    int limit_sets   = 0;
    int cycle_count  = 0;

    stepper_angle_positioner i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_valid        (req_valid),
        .req_ready        (req_ready),
        .action           (action),
        .target_angle     (target_angle),
        .driver_ready     (driver_ready),
        .cw_limit_closed  (cw_limit_closed),
        .ccw_limit_closed (ccw_limit_closed),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .running          (running),
        .clockwise        (clockwise),
        .steps_done       (steps_done),
        .step_counted     (step_counted),
        .position         (position)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // A closed end switch blocks motion only in the direction it guards. The
    // direction used is the one after any update by the current request.
    function automatic bit switch_blocks(move_req_t r);
        return (r.cw_lim && ax_cw) || (r.ccw_lim && !ax_cw);
    endfunction

    // Applies one request to the predicted axis state and returns the status
    // the block must report for it.
    function automatic axis_status_t advance_axis(move_req_t r);
        int           cur;
        int           tgt;
        int           span;
        longint       goal;
        axis_status_t s;
        s.counted = 1'b0;
        cur = ax_pos;
        if (r.action == ACT_MOVE) begin
            tgt = r.target;
            // A move is dropped when the driver is busy or the raw target is
            // already the recorded angle.
            if (r.drv_ready && tgt != cur) begin
                // The upper clamp comes last, so it wins when min is above max.
                if (tgt < lim_lo)
                    tgt = lim_lo;
                if (tgt > lim_hi)
                    tgt = lim_hi;
                ax_cw = tgt > cur;
                span  = (tgt > cur) ? tgt - cur : cur - tgt;
                goal  = (longint'(span) * STEPS_NUM + STEPS_DEN / 2) / STEPS_DEN;
                ax_goal = (goal > 65535) ? 16'hFFFF : 16'(goal);
                // A blocked start still moves the recorded angle and the goal,
                // but a motion already under way keeps its count and runs on.
                if (!switch_blocks(r)) begin
                    ax_count  = '0;
                    ax_moving = 1'b1;
                    ax_starts++;
                end
                ax_pos = 16'(tgt);
            end
        end else if (r.action == ACT_TICK) begin
            // Ticks only matter while the step timer runs; every second one
            // completes a step. The phase bit survives from one move to the next.
            if (ax_moving) begin
                ax_phase = !ax_phase;
                if (!ax_phase) begin
                    ax_count  = ax_count + 16'd1;
                    s.counted = 1'b1;
                    ax_steps++;
                    if (ax_count >= ax_goal)
                        ax_moving = 1'b0;
                end
            end
        end else if (r.action == ACT_LIMIT) begin
            if (switch_blocks(r))
                ax_moving = 1'b0;
        end
        s.running   = ax_moving;
        s.clockwise = ax_cw;
        s.steps     = ax_count;
        s.position  = ax_pos;
        return s;
    endfunction

    function automatic void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            faults++;
        end
    endfunction

    function automatic int rnd_angle();
        return $signed(16'($urandom));
    endfunction

    task automatic queue_req(logic [1:0] act, int tgt, bit drv, bit cw, bit ccw);
        move_req_t r;
        r.action    = act;
        r.target    = 16'(tgt);
        r.drv_ready = drv;
        r.cw_lim    = cw;
        r.ccw_lim   = ccw;
        req_backlog.push_back(r);
    endtask

    // Mostly well-formed motion: a move toward a target in the window, then a
    // run of ticks long enough to finish small moves, now and then a limit
    // event in the middle. The rest is loose requests of every kind.
    task automatic queue_random(int budget, int win_lo, int win_hi);
        int left;
        int ticks;
        int pick;
        int tgt;
        int k;
        left = budget;
        while (left > 0) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                if ($urandom_range(4) == 0)
                    tgt = rnd_angle();
                else
                    tgt = win_lo + int'($urandom_range(win_hi - win_lo));
                queue_req(ACT_MOVE, tgt, $urandom_range(9) != 0,
                          $urandom_range(7) == 0, $urandom_range(7) == 0);
                ticks = $urandom_range(45);
                for (k = 0; k < ticks; k++) begin
                    if ($urandom_range(29) == 0)
                        queue_req(ACT_LIMIT, rnd_angle(), 1'($urandom),
                                  1'($urandom), 1'($urandom));
                    else
                        queue_req(ACT_TICK, rnd_angle(), 1'($urandom),
                                  1'($urandom), 1'($urandom));
                end
                left -= ticks + 1;
            end else begin
                if (pick < 75)
                    queue_req(ACT_LIMIT, rnd_angle(), 1'($urandom), 1'($urandom),
                              1'($urandom));
                else if (pick < 80)
                    queue_req(ACT_SPARE, rnd_angle(), 1'($urandom), 1'($urandom),
                              1'($urandom));
                else if (pick < 92)
                    queue_req(ACT_TICK, rnd_angle(), 1'($urandom), 1'($urandom),
                              1'($urandom));
                else
                    queue_req(ACT_MOVE, rnd_angle(), 1'($urandom), 1'($urandom),
                              1'($urandom));
                left--;
            end
        end
    endtask

    // Waits until every queued request has gone in and every result is back,
    // then lets the two-stage pipeline go quiet.
    task automatic drain();
        while (req_backlog.size() != 0 || req_valid || status_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes both angle limits while the block is idle and mirrors them in
    // the predictor.
    task automatic write_limits(int lo, int hi);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = CFG_MIN_ANGLE;
        cfg_data  = 16'(lo);
        @(negedge clk);
        cfg_index = CFG_MAX_ANGLE;
        cfg_data  = 16'(hi);
        @(negedge clk);
        cfg_wr_en = 1'b0;
        lim_lo = 16'(lo);
        lim_hi = 16'(hi);
        limit_sets++;
    endtask

    // Request driver. A new request is offered only after the previous one
    // was taken (or nothing was offered), so valid never drops early.
    always @(negedge clk)
    begin
        if (!req_valid || req_taken) begin
            if (req_backlog.size() != 0 && (steady || $urandom_range(99) >= 19)) begin
                head_req = req_backlog.pop_front();
                action           <= head_req.action;
                target_angle     <= head_req.target;
                driver_ready     <= head_req.drv_ready;
                cw_limit_closed  <= head_req.cw_lim;
                ccw_limit_closed <= head_req.ccw_lim;
                req_valid        <= 1'b1;
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // Result receiver. Once enough results have come back it holds off for a
    // long stretch while the driver keeps offering requests, so the pipeline
    // fills and the block must drop req_ready.
    always @(negedge clk)
    begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            res_ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            res_ready <= 1'b0;
        end else begin
            res_ready <= steady || $urandom_range(99) >= 19;
        end
    end

    // Monitor. Every request taken is run through the predictor at once; every
    // result taken is checked against the oldest prediction.
    always @(posedge clk)
    begin
        req_taken = rst_n && req_valid && req_ready;
        if (req_taken) begin
            seen_req = '{action, target_angle, driver_ready, cw_limit_closed,
                         ccw_limit_closed};
            status_due.push_back(advance_axis(seen_req));
            reqs_sent++;
        end
        if (rst_n && res_valid && res_ready) begin
            results_seen++;
            if (status_due.size() == 0) begin
                $error("result with no request outstanding");
                faults++;
            end else begin
                want = status_due.pop_front();
                check_field("running", want.running, running);
                check_field("clockwise", want.clockwise, clockwise);
                check_field("steps_done", want.steps, steps_done);
                check_field("step_counted", want.counted, step_counted);
                check_field("position", want.position, position);
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("stepper_angle_positioner verification failed");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Limits still at reset, both zero: every move clamps to the current
        // angle, so a move with a different raw target starts with a zero goal
        // and stops at the first counted step. Ticks while stopped do nothing.
        queue_req(ACT_TICK, 0, 1'b1, 1'b0, 1'b0);
        queue_req(ACT_MOVE, 1000, 1'b1, 1'b0, 1'b0);
        queue_req(ACT_TICK, -1, 1'b0, 1'b1, 1'b1);
        queue_req(ACT_TICK, 0, 1'b1, 1'b0, 1'b0);
        queue_req(ACT_SPARE, 32767, 1'b1, 1'b1, 1'b1);
        drain();

        // Widest limits, then the directed cases.
        write_limits(-32768, 32767);
        queue_req(ACT_MOVE, 500, 1'b0, 1'b0, 1'b0);       // driver busy
        queue_req(ACT_MOVE, 0, 1'b1, 1'b0, 1'b0);         // already there
        queue_req(ACT_MOVE, 32767, 1'b1, 1'b1, 1'b0);     // blocked clockwise
        queue_req(ACT_MOVE, -32768, 1'b1, 1'b1, 1'b1);    // blocked, largest goal
        queue_req(ACT_MOVE, -32728, 1'b1, 1'b0, 1'b0);    // short clockwise move
        queue_req(ACT_TICK, 0, 1'b1, 1'b0, 1'b0);
        queue_req(ACT_TICK, 0, 1'b1, 1'b0, 1'b0);
        queue_req(ACT_LIMIT, 0, 1'b1, 1'b0, 1'b1);        // wrong side, keeps going
        queue_req(ACT_TICK, 0, 1'b1, 1'b0, 1'b0);         // leaves the phase odd
        queue_req(ACT_MOVE, -32648, 1'b1, 1'b1, 1'b0);    // blocked while running
        repeat (5) queue_req(ACT_TICK, 0, 1'b1, 1'b0, 1'b0);
        queue_req(ACT_TICK, 0, 1'b1, 1'b0, 1'b0);         // already stopped, changes nothing
        queue_req(ACT_MOVE, -32600, 1'b1, 1'b0, 1'b0);    // starts with the phase at zero
        queue_req(ACT_TICK, 0, 1'b1, 1'b0, 1'b0);
        queue_req(ACT_LIMIT, 0, 1'b1, 1'b1, 1'b0);        // clockwise switch stops it
        queue_req(ACT_MOVE, 32767, 1'b1, 1'b0, 1'b0);
        queue_req(ACT_TICK, -32768, 1'b0, 1'b1, 1'b1);
        queue_req(ACT_TICK, 32767, 1'b1, 1'b1, 1'b1);
        queue_req(ACT_LIMIT, 0, 1'b1, 1'b1, 1'b1);
        queue_req(ACT_SPARE, -32768, 1'b0, 1'b0, 1'b0);
        queue_random(130, -200, 200);
        drain();

        // Narrow limits around zero, sent back to back with no idling at all.
        write_limits(-150, 150);
        steady = 1'b1;
        queue_random(130, -200, 200);
        drain();
        steady = 1'b0;

        // Narrow limits pressed against each end of the angle range.
        write_limits(32467, 32767);
        queue_random(130, 32400, 32767);
        drain();
        write_limits(-32768, -32468);
        queue_random(130, -32768, -32400);
        drain();

        // Minimum above maximum: the maximum wins on every clamp.
        write_limits(100, -100);
        queue_random(60, -200, 200);
        drain();

        // A random narrow window somewhere in the range.
        write_limits(-20000 + int'($urandom_range(200)), -19800 + int'($urandom_range(200)));
        queue_random(50, -20100, -19500);
        drain();

        repeat (8) @(posedge clk);
        if (status_due.size() != 0) begin
            $error("%0d results never arrived", status_due.size());
            faults++;
        end

        $display("Covered %0d requests and %0d checked results under %0d angle-limit settings.",
                 reqs_sent, results_seen, limit_sets);
        $display("The axis started %0d moves and counted %0d steps.", ax_starts, ax_steps);
        if (faults == 0)
            $display("stepper_angle_positioner verification clean");
        else
            $display("stepper_angle_positioner verification failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/sap_pkg.sv
hdl/sap_move_calc.sv
hdl/stepper_angle_positioner.sv
bench/tb_top.sv
